// ----- rtl/core/bc123_pkg.sv -----
// shared types, register codes and divide helpers for the block decoder
`timescale 1ns / 1ps
package bc123_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 16384;
    localparam int CFG_ADDR_W            = 4;
    localparam int CFG_DATA_W            = 32;
    localparam int DIM_CFG_W             = 15;
    localparam int POS_W                 = 14;

    localparam logic [9:0]  RECIP3 = 10'd683;
    localparam logic [11:0] RECIP5 = 12'd3277;
    localparam logic [11:0] RECIP7 = 12'd2341;

    typedef enum logic [1:0] {
        FMT_BC1  = 2'd0,
        FMT_BC2  = 2'd1,
        FMT_BC3  = 2'd2,
        FMT_NONE = 2'd3
    } t_format;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [63:0] alpha_word;
        logic [63:0] color_word;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] pixel_x;
        logic [POS_W-1:0] pixel_y;
        logic [31:0]      rgba_first;
        logic [31:0]      rgba_second;
        logic [31:0]      rgba_third;
        logic [31:0]      rgba_fourth;
        logic [3:0]       lane_valid;
        logic             last_of_block;
        logic             last_of_image;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] y0;
        logic [2:0]       rows;
        logic [3:0]       lane_valid;
        logic             last_block;
    } t_blk_pos;

    typedef logic [3:0][31:0] t_palette;
    typedef logic [7:0][7:0]  t_alpha_tab;

    // floor(x / 3) for x below 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(RECIP3);
        return p[18:11];
    endfunction

    // floor(x / 5) for x below 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(RECIP5);
        return p[21:14];
    endfunction

    // floor(x / 7) for x below 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(RECIP7);
        return p[21:14];
    endfunction

endpackage

// ----- rtl/core/bc1_bc2_bc3_block_decoder.sv -----
// the first row of a block passes from the input register through the table stage to the output register
// throughput: one row per cycle while the output is not stalled; a full block has four rows, clipped blocks fewer
// the row emitter sets the rate, the next block waits in the input register behind it
// input and table stages overlap emission, so blocks follow one another without gaps
// reset: pipeline empty, block counters zero, format bc1, image 1 x 1 pixels
`timescale 1ns / 1ps
module bc1_bc2_bc3_block_decoder #(
    parameter int MAX_DIMENSION = bc123_pkg::DEFAULT_MAX_DIMENSION
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bc123_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bc123_pkg::t_out_item             o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bc123_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bc123_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bc123_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import bc123_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = $clog2((MAX_DIMENSION + 3) / 4 + 1);

    function automatic logic [DW-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        if (e == 32'd0) begin
            e = 32'd1;
        end else if (e > 32'(MAX_DIMENSION)) begin
            e = 32'(MAX_DIMENSION);
        end
        return e[DW-1:0];
    endfunction

    function automatic logic [CW-1:0] block_count(input logic [DW-1:0] d);
        logic [DW:0] s;
        s = {1'b0, d} + (DW+1)'(3);
        return CW'(s >> 2);
    endfunction

    // configuration
    t_format                r_format;
    logic [DIM_CFG_W-1:0]   r_image_width;
    logic [DIM_CFG_W-1:0]   r_image_height;
    logic [DW-1:0]          r_w_eff;
    logic [DW-1:0]          r_h_eff;
    logic [CW-1:0]          r_bx_n;
    logic [CW-1:0]          r_by_n;
    logic                   w_cfg_wr;

    // block position
    logic [CW-1:0]          r_col;
    logic [CW-1:0]          r_brow;

    // input stage
    logic                   r_s1_valid;
    t_in_item               r_s1_item;
    t_blk_pos               r_s1_pos;
    t_blk_pos               n_s1_pos;

    // table stage
    logic                   r_s2_valid;
    t_palette               r_s2_pal;
    t_alpha_tab             r_s2_atab;
    logic [63:0]            r_s2_aw;
    logic [31:0]            r_s2_cidx;
    t_blk_pos               r_s2_pos;
    logic [1:0]             r_row;
    t_palette               w_pal;
    t_alpha_tab             w_atab;

    // output register
    logic                   r_out_valid;
    t_out_item              r_out_item;
    t_out_item              n_out_item;

    logic                   w_s1_load;
    logic                   w_s2_load;
    logic                   w_out_load;
    logic                   w_row_last;
    logic                   w_s2_done;
    logic [DW-1:0]          w_x0;
    logic [DW-1:0]          w_y0;
    logic [DW-1:0]          w_rem_w;
    logic [DW-1:0]          w_rem_h;
    logic [3:0][31:0]       w_px;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg_index'(paddr[3:2]))
            REG_FORMAT: prdata = CFG_DATA_W'(r_format);
            REG_WIDTH:  prdata = CFG_DATA_W'(r_image_width);
            REG_HEIGHT: prdata = CFG_DATA_W'(r_image_height);
            default:    prdata = '0;
        endcase
    end

    // handshake between stages
    assign w_row_last = ({1'b0, r_row} + 3'd1) == r_s2_pos.rows;
    assign w_out_load = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign w_s2_done  = w_out_load && w_row_last;
    assign w_s2_load  = r_s1_valid && (!r_s2_valid || w_s2_done);
    assign o_in_stall = r_s1_valid && !w_s2_load;
    assign w_s1_load  = i_in_valid && !o_in_stall;

    // placement of the block being taken
    always_comb begin
        w_x0    = DW'({r_col, 2'b00});
        w_y0    = DW'({r_brow, 2'b00});
        w_rem_w = r_w_eff - w_x0;
        w_rem_h = r_h_eff - w_y0;
        n_s1_pos.x0   = POS_W'(w_x0);
        n_s1_pos.y0   = POS_W'(w_y0);
        n_s1_pos.rows = (w_rem_h >= DW'(4)) ? 3'd4 : w_rem_h[2:0];
        for (int k = 0; k < 4; k++) begin
            n_s1_pos.lane_valid[k] = w_rem_w > DW'(k);
        end
        n_s1_pos.last_block = (r_col + CW'(1) == r_bx_n) && (r_brow + CW'(1) == r_by_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format       <= FMT_BC1;
            r_image_width  <= DIM_CFG_W'(1);
            r_image_height <= DIM_CFG_W'(1);
            r_w_eff        <= DW'(1);
            r_h_eff        <= DW'(1);
            r_bx_n         <= CW'(1);
            r_by_n         <= CW'(1);
            r_col          <= '0;
            r_brow         <= '0;
        end else if (w_cfg_wr) begin
            case (t_reg_index'(paddr[3:2]))
                REG_FORMAT: begin
                    r_format <= t_format'(pwdata[1:0]);
                end
                REG_WIDTH: begin
                    r_image_width <= pwdata[DIM_CFG_W-1:0];
                    r_w_eff       <= eff_dim(pwdata[DIM_CFG_W-1:0]);
                    r_bx_n        <= block_count(eff_dim(pwdata[DIM_CFG_W-1:0]));
                    r_col         <= '0;
                    r_brow        <= '0;
                end
                REG_HEIGHT: begin
                    r_image_height <= pwdata[DIM_CFG_W-1:0];
                    r_h_eff        <= eff_dim(pwdata[DIM_CFG_W-1:0]);
                    r_by_n         <= block_count(eff_dim(pwdata[DIM_CFG_W-1:0]));
                    r_col          <= '0;
                    r_brow         <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_s1_load) begin
            if (r_col + CW'(1) == r_bx_n) begin
                r_col  <= '0;
                r_brow <= (r_brow + CW'(1) == r_by_n) ? '0 : r_brow + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    bc123_tables u_tables (
        .i_c0        (r_s1_item.color_word[15:0]),
        .i_c1        (r_s1_item.color_word[31:16]),
        .i_a0        (r_s1_item.alpha_word[7:0]),
        .i_a1        (r_s1_item.alpha_word[15:8]),
        .i_punch     (r_format == FMT_BC1),
        .o_palette   (w_pal),
        .o_alpha_tab (w_atab)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_load) begin
                r_s2_valid <= 1'b1;
                r_row      <= '0;
            end else begin
                if (w_s2_done) begin
                    r_s2_valid <= 1'b0;
                end
                if (w_out_load) begin
                    r_row <= r_row + 2'd1;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_item <= i_in_item;
            r_s1_pos  <= n_s1_pos;
        end
        if (w_s2_load) begin
            r_s2_pal  <= w_pal;
            r_s2_atab <= w_atab;
            r_s2_aw   <= r_s1_item.alpha_word;
            r_s2_cidx <= r_s1_item.color_word[63:32];
            r_s2_pos  <= r_s1_pos;
        end
        if (w_out_load) begin
            r_out_item <= n_out_item;
        end
    end

    // pixels of the current row
    always_comb begin
        logic [7:0]  cidx_row;
        logic [15:0] nib_row;
        logic [11:0] aidx_row;
        logic [1:0]  cidx;
        logic [3:0]  nib;
        logic [2:0]  aidx;
        logic [31:0] px;
        cidx_row = r_s2_cidx[8*r_row +: 8];
        nib_row  = r_s2_aw[16*r_row +: 16];
        aidx_row = r_s2_aw[16 + 12*r_row +: 12];
        for (int k = 0; k < 4; k++) begin
            cidx = cidx_row[2*k +: 2];
            nib  = nib_row[4*k +: 4];
            aidx = aidx_row[3*k +: 3];
            px   = r_s2_pal[cidx];
            case (r_format)
                FMT_BC1: px = r_s2_pal[cidx];
                FMT_BC2: px = {nib, nib, r_s2_pal[cidx][23:0]};
                FMT_BC3: px = {r_s2_atab[aidx], r_s2_pal[cidx][23:0]};
                default: px = '0;
            endcase
            w_px[k] = r_s2_pos.lane_valid[k] ? px : 32'd0;
        end
        n_out_item.pixel_x       = r_s2_pos.x0;
        n_out_item.pixel_y       = r_s2_pos.y0 + POS_W'(r_row);
        n_out_item.rgba_first    = w_px[0];
        n_out_item.rgba_second   = w_px[1];
        n_out_item.rgba_third    = w_px[2];
        n_out_item.rgba_fourth   = w_px[3];
        n_out_item.lane_valid    = r_s2_pos.lane_valid;
        n_out_item.last_of_block = w_row_last;
        n_out_item.last_of_image = w_row_last && r_s2_pos.last_block;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_row_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> ({1'b0, r_row} < r_s2_pos.rows))
        else $error("row counter past the rows of the block");

    a_counters_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < r_bx_n) && (r_brow < r_by_n))
        else $error("block counters outside the image");

    a_image_end_is_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_of_image |-> o_out_item.last_of_block)
        else $error("image end flagged on a row that does not end its block");

    a_first_lane_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.lane_valid[0])
        else $error("row item with its first lane outside the image");

    a_block_done_frees_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_done && !w_s2_load |=> !r_s2_valid)
        else $error("table stage still busy after its last row");
`endif

endmodule

// ----- rtl/core/bc123_tables.sv -----
// colour palette and alpha table of one block
`timescale 1ns / 1ps
module bc123_tables (
    input  logic [15:0]           i_c0,
    input  logic [15:0]           i_c1,
    input  logic [7:0]            i_a0,
    input  logic [7:0]            i_a1,
    input  logic                  i_punch,
    output bc123_pkg::t_palette   o_palette,
    output bc123_pkg::t_alpha_tab o_alpha_tab
);
    import bc123_pkg::*;

    logic [2:0][7:0]  w_e0;
    logic [2:0][7:0]  w_e1;
    logic [2:0][7:0]  w_mid2;
    logic [2:0][7:0]  w_mid3;
    logic             w_four;
    logic [5:0][10:0] w_sum7;
    logic [3:0][10:0] w_sum5;

    // endpoints widen by a plain shift
    always_comb begin
        w_e0[0] = {i_c0[15:11], 3'b000};
        w_e0[1] = {i_c0[10:5], 2'b00};
        w_e0[2] = {i_c0[4:0], 3'b000};
        w_e1[0] = {i_c1[15:11], 3'b000};
        w_e1[1] = {i_c1[10:5], 2'b00};
        w_e1[2] = {i_c1[4:0], 3'b000};
        w_four  = i_c0 > i_c1;
        for (int j = 0; j < 3; j++) begin
            if (w_four) begin
                w_mid2[j] = div3({1'b0, w_e0[j], 1'b0} + {2'b00, w_e1[j]} + 10'd1);
                w_mid3[j] = div3({2'b00, w_e0[j]} + {1'b0, w_e1[j], 1'b0} + 10'd1);
            end else begin
                w_mid2[j] = 8'(({1'b0, w_e0[j]} + {1'b0, w_e1[j]}) >> 1);
                w_mid3[j] = 8'd0;
            end
        end
        o_palette[0] = {8'hFF, w_e0[2], w_e0[1], w_e0[0]};
        o_palette[1] = {8'hFF, w_e1[2], w_e1[1], w_e1[0]};
        o_palette[2] = {8'hFF, w_mid2[2], w_mid2[1], w_mid2[0]};
        o_palette[3] = {((w_four || !i_punch) ? 8'hFF : 8'h00),
                        w_mid3[2], w_mid3[1], w_mid3[0]};
    end

    // interpolated alpha, seven-step or five-step with the fixed ends
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_sum7[i] = 11'(6 - i) * {3'b000, i_a0} + 11'(1 + i) * {3'b000, i_a1} + 11'd3;
        end
        for (int i = 0; i < 4; i++) begin
            w_sum5[i] = 11'(4 - i) * {3'b000, i_a0} + 11'(1 + i) * {3'b000, i_a1} + 11'd2;
        end
        o_alpha_tab[0] = i_a0;
        o_alpha_tab[1] = i_a1;
        if (i_a0 > i_a1) begin
            for (int i = 0; i < 6; i++) begin
                o_alpha_tab[2 + i] = div7(w_sum7[i]);
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                o_alpha_tab[2 + i] = div5(w_sum5[i]);
            end
            o_alpha_tab[6] = 8'h00;
            o_alpha_tab[7] = 8'hFF;
        end
    end

endmodule
